[hw/rtl/saq_pkg.sv]
// Shared types and constants for the sorted-array priority queue.
package saq_pkg;

  localparam int CNT_W    = 32;
  localparam int FLD_W    = 16;
  localparam int OCC_W    = 5;
  localparam int IN_TD_W  = 32;
  localparam int OUT_TD_W = 168;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic load;
    logic deq;
  } cell_ctl_t;

  typedef struct packed {
    logic enq_ok;
    logic deq_ok;
    logic ovf;
  } stats_evt_t;

endpackage

[hw/rtl/sorted_array_priority_queue.sv]
// Sorted-array priority queue top level: a row of slots, counters and the result register.
// Takes one word per clock: every slot compares its key against the incoming key at once,
// so an enqueue or dequeue updates the whole row at once and its result word is
// in the output register on the next cycle. A new word is taken whenever the output
// register is empty or being read in the same cycle. No clearing pass after reset.
// Larger keys leave first; equal keys leave in arrival order. A full-queue enqueue and an
// empty-queue dequeue return accepted = 0 with zero key and tag.
module sorted_array_priority_queue
  import saq_pkg::*;
#(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_TD_W-1:0]  in_tdata,   // key[15:0], tag[31:16]
  input  logic                in_tuser,   // opcode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata,  // out_key[15:0], out_tag[31:16], is_empty[32],
                                          // occupancy[37:33], inserted_total[69:38],
                                          // removed_total[101:70], moved_total[133:102],
                                          // overflow_total[165:134], zero pad
  output logic                out_tuser   // accepted
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [KEY_BITS-1:0] new_key;
  logic [TAG_BITS-1:0] new_tag;
  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [TAG_BITS-1:0] cell_tag [DEPTH];
  logic [DEPTH-1:0]    cell_ge;
  logic [DEPTH-1:0]    cell_prev_ge;
  logic [DEPTH-1:0]    cell_occ;
  logic [DEPTH-1:0]    ins_hot;
  logic [IW-1:0]       ins_pos;

  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r;
  logic                acc_r;
  logic [FLD_W-1:0]    out_key_r, out_tag_r;

  logic                fire, is_deq, full, empty;
  cell_ctl_t           ctl;
  stats_evt_t          evt;
  logic [CNT_W-1:0]    moves;
  logic [CNT_W-1:0]    inserted, removed, moved, overflowed;

  assign new_key   = KEY_BITS'(in_tdata[FLD_W-1:0]);
  assign new_tag   = TAG_BITS'(in_tdata[2*FLD_W-1:FLD_W]);
  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;
  assign is_deq    = (in_tuser == OP_DEQ);
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  assign evt.enq_ok = fire && !is_deq && !full;
  assign evt.deq_ok = fire && is_deq && !empty;
  assign evt.ovf    = fire && !is_deq && full;
  assign ctl.load   = evt.enq_ok || evt.deq_ok;
  assign ctl.deq    = is_deq;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] pk, nk;
    logic [TAG_BITS-1:0] pt, nt;

    assign cell_occ[i] = (CW'(i) < count_r);
    if (i == 0) begin : g_head
      assign cell_prev_ge[i] = 1'b1;
      assign pk = new_key;
      assign pt = new_tag;
    end else begin : g_body
      assign cell_prev_ge[i] = cell_ge[i-1];
      assign pk = cell_key[i-1];
      assign pt = cell_tag[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nk = cell_key[i];
      assign nt = cell_tag[i];
    end else begin : g_mid
      assign nk = cell_key[i+1];
      assign nt = cell_tag[i+1];
    end
    assign ins_hot[i] = !cell_ge[i] && cell_prev_ge[i];

    saq_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (cell_occ[i]),
      .new_key  (new_key),
      .new_tag  (new_tag),
      .prev_ge  (cell_prev_ge[i]),
      .prev_key (pk),
      .prev_tag (pt),
      .next_key (nk),
      .next_tag (nt),
      .key      (cell_key[i]),
      .tag      (cell_tag[i]),
      .ge       (cell_ge[i])
    );
  end

  // insert point is one-hot, so an OR encoder gives its index
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ins_hot[i]) begin
        ins_pos = ins_pos | IW'(i);
      end
    end
  end

  always_comb begin
    moves     = '0;
    count_nxt = count_r;
    if (evt.enq_ok) begin
      moves     = CNT_W'(count_r) - CNT_W'(ins_pos);
      count_nxt = count_r + CW'(1);
    end else if (evt.deq_ok) begin
      moves     = CNT_W'(count_r) - CNT_W'(1);
      count_nxt = count_r - CW'(1);
    end
  end

  saq_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt        (evt),
    .moves      (moves),
    .inserted   (inserted),
    .removed    (removed),
    .moved      (moved),
    .overflowed (overflowed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r     <= evt.enq_ok || evt.deq_ok;
      out_key_r <= evt.deq_ok ? FLD_W'(cell_key[0]) : '0;
      out_tag_r <= evt.deq_ok ? FLD_W'(cell_tag[0]) : '0;
    end
  end

  // state fields read the live registers: they only move when a word is taken
  assign out_tvalid = out_valid_r;
  assign out_tuser  = acc_r;
  assign out_tdata  = {2'b00, overflowed, moved, removed, inserted,
                       OCC_W'(count_r), empty, out_tag_r, out_key_r};

endmodule

[hw/rtl/saq_cell.sv]
// One queue slot: holds a key and tag, compares against the incoming key.
module saq_cell
  import saq_pkg::*;
#(
  parameter int KEY_BITS = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic                occ,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic                prev_ge,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic [TAG_BITS-1:0] prev_tag,
  input  logic [KEY_BITS-1:0] next_key,
  input  logic [TAG_BITS-1:0] next_tag,
  output logic [KEY_BITS-1:0] key,
  output logic [TAG_BITS-1:0] tag,
  output logic                ge
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;

  // entries ahead of the insert point hold equal-or-larger keys
  assign ge = occ && (key_r >= new_key);

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctl.load) begin
      if (ctl.deq) begin
        key_nxt = next_key;
        tag_nxt = next_tag;
      end else if (!ge) begin
        if (prev_ge) begin
          key_nxt = new_key;
          tag_nxt = new_tag;
        end else begin
          key_nxt = prev_key;
          tag_nxt = prev_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign key = key_r;
  assign tag = tag_r;

endmodule

[hw/rtl/saq_stats.sv]
// Wrapping insert, remove, move and overflow counters.
module saq_stats
  import saq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  stats_evt_t       evt,
  input  logic [CNT_W-1:0] moves,
  output logic [CNT_W-1:0] inserted,
  output logic [CNT_W-1:0] removed,
  output logic [CNT_W-1:0] moved,
  output logic [CNT_W-1:0] overflowed
);

  logic [CNT_W-1:0] ins_r, ins_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] mov_r, mov_nxt;
  logic [CNT_W-1:0] ovf_r, ovf_nxt;

  always_comb begin
    ins_nxt = ins_r + CNT_W'(evt.enq_ok);
    rem_nxt = rem_r + CNT_W'(evt.deq_ok);
    mov_nxt = mov_r + moves;
    ovf_nxt = ovf_r + CNT_W'(evt.ovf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_r <= '0;
      rem_r <= '0;
      mov_r <= '0;
      ovf_r <= '0;
    end else begin
      ins_r <= ins_nxt;
      rem_r <= rem_nxt;
      mov_r <= mov_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign inserted   = ins_r;
  assign removed    = rem_r;
  assign moved      = mov_r;
  assign overflowed = ovf_r;

endmodule

[hw/rtl/saq_checker.sv]
// Port-level checks for the sorted-array priority queue, bound to the top level.
module saq_checker
  import saq_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                in_tuser,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_TD_W-1:0] out_tdata,
  input logic                out_tuser
);

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted word produced no result");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[2*FLD_W-1:0] == '0)
    else $error("refused operation returned nonzero key or tag");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == OP_DEQ && !out_tdata[32]
      |=> out_tdata[101:70] == $past(out_tdata[101:70]) + 32'd1 && out_tuser)
    else $error("dequeue on nonempty queue not counted");

  a_enq_no_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == OP_ENQ |=> $stable(out_tdata[101:70]))
    else $error("enqueue changed remove count");

endmodule

bind sorted_array_priority_queue saq_checker u_saq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
